>>> rtl/cssg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cssg_pkg
// Shared types and constants for the constant-speed step generator.
// ----------------------------------------------------------------------------
package cssg_pkg;

  localparam int STEP_W     = 24;
  localparam int RPM_W      = 16;
  localparam int POS_W      = 32;
  localparam int HP_W       = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;

  // ticks per minute, the dividend of the half-period
  localparam int TICKS_PER_MIN = 60000;
  localparam int MICRO_RATIO   = 16;

  localparam int DEF_FULL_STEPS_PER_REV = 200;
  localparam int DEF_MAX_RPM            = 600;

  localparam logic [CFG_IDX_W-1:0] CFG_MICROSTEP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 1'd1;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_ZERO  = 2'd3
  } op_t;

  // request to the half-period unit
  typedef struct packed {
    logic             start;
    logic             sixteenth;
    logic [RPM_W-1:0] rpm;
  } hp_req_t;

endpackage

`default_nettype wire

>>> rtl/cssg_hp_calc.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cssg_hp_calc
// Half-period unit: bit-serial rpm * steps-per-rev, then a bit-serial
// restoring division of the ticks per minute by that product.
// ----------------------------------------------------------------------------
module cssg_hp_calc #(
  parameter int FULL_STEPS_PER_REV = cssg_pkg::DEF_FULL_STEPS_PER_REV,
  parameter int MAX_RPM            = cssg_pkg::DEF_MAX_RPM
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cssg_pkg::hp_req_t      req,
  output logic                        done,
  output logic [cssg_pkg::HP_W-1:0]   half_period
);
  import cssg_pkg::*;

  localparam int SPR_W  = $clog2(FULL_STEPS_PER_REV * MICRO_RATIO + 1);
  localparam int PROD_W = RPM_W + SPR_W;
  localparam int CNT_W  = $clog2(HP_W);

  localparam logic [SPR_W-1:0] SPR_FULL  = SPR_W'(FULL_STEPS_PER_REV);
  localparam logic [SPR_W-1:0] SPR_MICRO = SPR_W'(FULL_STEPS_PER_REV * MICRO_RATIO);
  localparam logic [RPM_W-1:0] RPM_LIMIT = RPM_W'(MAX_RPM);
  localparam logic [HP_W-1:0]  DIVIDEND  = HP_W'(TICKS_PER_MIN);

  typedef enum logic [1:0] {
    C_IDLE,
    C_MUL,
    C_DIV
  } calc_state_t;

  calc_state_t       state;
  logic [CNT_W-1:0]  cnt;
  logic [RPM_W-1:0]  mul_sr;
  logic [SPR_W-1:0]  spr;
  logic [PROD_W-1:0] acc;
  logic [HP_W-1:0]   dvd_sr;
  logic [HP_W-1:0]   rem;
  logic [HP_W-1:0]   quot;

  logic [PROD_W-1:0] acc_next;
  logic [PROD_W:0]   trial;
  logic              fits;
  logic [PROD_W:0]   trial_diff;

  assign acc_next   = {acc[PROD_W-2:0], 1'b0} +
                      (mul_sr[RPM_W-1] ? PROD_W'(spr) : '0);
  assign trial      = {{(PROD_W-HP_W){1'b0}}, rem, dvd_sr[HP_W-1]};
  assign fits       = trial >= {1'b0, acc};
  assign trial_diff = trial - {1'b0, acc};

  // quotient of zero still gives one tick
  assign half_period = (quot == '0) ? HP_W'(1) : quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
      quot  <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        C_IDLE: begin
          if (req.start) begin
            mul_sr <= (req.rpm > RPM_LIMIT) ? RPM_LIMIT : req.rpm;
            spr    <= req.sixteenth ? SPR_MICRO : SPR_FULL;
            acc    <= '0;
            cnt    <= CNT_W'(HP_W - 1);
            state  <= C_MUL;
          end
        end
        C_MUL: begin
          acc    <= acc_next;
          mul_sr <= {mul_sr[RPM_W-2:0], 1'b0};
          cnt    <= cnt - 1'b1;
          if (cnt == '0) begin
            dvd_sr <= DIVIDEND;
            rem    <= '0;
            quot   <= '0;
            cnt    <= CNT_W'(HP_W - 1);
            state  <= C_DIV;
          end
        end
        C_DIV: begin
          rem    <= fits ? trial_diff[HP_W-1:0] : trial[HP_W-1:0];
          quot   <= {quot[HP_W-2:0], fits};
          dvd_sr <= {dvd_sr[HP_W-2:0], 1'b0};
          cnt    <= cnt - 1'b1;
          if (cnt == '0) begin
            done  <= 1'b1;
            state <= C_IDLE;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_start_only_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> state == C_IDLE)
    else $error("half-period request while busy");

  a_done_after_div: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == C_DIV)
    else $error("done without a division pass");

  a_hp_nonzero: assert property (@(posedge clk) disable iff (rst)
    half_period != '0)
    else $error("half-period is zero");
`endif

endmodule

`default_nettype wire

>>> rtl/constant_speed_step_generator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// constant_speed_step_generator_unit
// Step/direction pulse generator for a stepper driver at constant speed.
// ----------------------------------------------------------------------------
// Each input beat gives exactly one result beat. Tick, stop and zero beats
// and starts with zero steps or zero rpm return their result in the cycle
// after acceptance. A real start returns its result once the half-period
// unit is done: it multiplies rpm by steps per revolution one bit a cycle,
// then divides 60000 by the product one quotient bit a cycle; its done flag
// is registered, and the result beat is registered from it.
// One beat is in flight at a time; the next is taken once its result has
// been handed off or leaves in the same cycle. The step level toggles on
// every acting tick that does not end the move, position moves on each
// falling step edge, and the half-period of a move is fixed when it starts.
// ----------------------------------------------------------------------------
module constant_speed_step_generator_unit #(
  parameter int FULL_STEPS_PER_REV = cssg_pkg::DEF_FULL_STEPS_PER_REV,
  parameter int MAX_RPM            = cssg_pkg::DEF_MAX_RPM
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [cssg_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  wire logic [cssg_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [1:0]                       op,
  input  wire logic [cssg_pkg::STEP_W-1:0]      step_count,
  input  wire logic                             forward,
  input  wire logic [cssg_pkg::RPM_W-1:0]       speed_rpm,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  step_level,
  output logic                                  dir_level,
  output logic                                  enable_n,
  output logic                                  busy_res,
  output logic                                  done_res,
  output logic signed [cssg_pkg::POS_W-1:0]     position
);
  import cssg_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_CALC
  } state_t;

  state_t            state;
  logic              microstep_sixteenth;
  logic              hold_torque;
  logic [POS_W-1:0]  position_count;
  logic [POS_W-1:0]  target_position;
  logic              running;
  logic              step_high;
  logic              move_forward;
  logic [HP_W-1:0]   half_period;
  logic [HP_W-1:0]   wait_ticks;
  logic              driver_on;
  logic              done_flag;
  logic [STEP_W-1:0] saved_steps;
  logic              saved_fwd;

  logic              in_fire;
  op_t               op_code;
  logic              start_null;
  logic              tick_end;
  hp_req_t           hp_req;
  logic              hp_done;
  logic [HP_W-1:0]   hp_value;

  assign in_ready   = (state == S_IDLE) && (!out_valid || out_ready);
  assign in_fire    = in_valid && in_ready;
  assign op_code    = op_t'(op);
  assign start_null = (step_count == '0) || (speed_rpm == '0);
  // an acting tick that finds the target reached ends the move
  assign tick_end   = running && (wait_ticks == '0) &&
                      (position_count == target_position);

  assign hp_req.start     = in_fire && (op_code == OP_START) && !start_null;
  assign hp_req.sixteenth = microstep_sixteenth;
  assign hp_req.rpm       = speed_rpm;

  cssg_hp_calc #(
    .FULL_STEPS_PER_REV (FULL_STEPS_PER_REV),
    .MAX_RPM            (MAX_RPM)
  ) u_hp_calc (
    .clk         (clk),
    .rst         (rst),
    .req         (hp_req),
    .done        (hp_done),
    .half_period (hp_value)
  );

  // result fields read state directly; state moves only when a beat is taken
  assign step_level = step_high;
  assign dir_level  = !move_forward;
  assign enable_n   = !driver_on;
  assign busy_res   = running;
  assign done_res   = done_flag;
  assign position   = position_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_IDLE;
      microstep_sixteenth <= 1'b1;
      hold_torque         <= 1'b1;
      position_count      <= '0;
      target_position     <= '0;
      running             <= 1'b0;
      step_high           <= 1'b0;
      move_forward        <= 1'b0;
      half_period         <= HP_W'(1);
      wait_ticks          <= '0;
      driver_on           <= 1'b0;
      done_flag           <= 1'b0;
      out_valid           <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_MICROSTEP: microstep_sixteenth <= cfg_data[0];
          CFG_HOLD:      hold_torque         <= cfg_data[0];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (in_fire) begin
            // a real start holds its result until the half-period is ready
            out_valid <= !hp_req.start;
            case (op_code)
              OP_TICK: begin
                done_flag <= tick_end;
                if (running) begin
                  if (wait_ticks != '0) begin
                    wait_ticks <= wait_ticks - 1'b1;
                  end else if (position_count == target_position) begin
                    step_high <= 1'b0;
                    driver_on <= hold_torque;
                    running   <= 1'b0;
                  end else begin
                    wait_ticks <= half_period - 1'b1;
                    step_high  <= !step_high;
                    // position moves on the falling step edge
                    if (step_high) begin
                      position_count <= move_forward ? position_count + 1'b1
                                                     : position_count - 1'b1;
                    end
                  end
                end
              end
              OP_START: begin
                done_flag <= 1'b0;
                if (start_null) begin
                  step_high <= 1'b0;
                  driver_on <= hold_torque;
                  running   <= 1'b0;
                end else begin
                  saved_steps <= step_count;
                  saved_fwd   <= forward;
                  state       <= S_CALC;
                end
              end
              OP_STOP: begin
                done_flag <= running;
                running   <= 1'b0;
                step_high <= 1'b0;
                driver_on <= hold_torque;
              end
              OP_ZERO: begin
                done_flag      <= 1'b0;
                position_count <= '0;
              end
              default: ;
            endcase
          end else if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
        S_CALC: begin
          if (hp_done) begin
            half_period     <= hp_value;
            running         <= 1'b1;
            target_position <= saved_fwd
                               ? position_count + POS_W'(saved_steps)
                               : position_count - POS_W'(saved_steps);
            move_forward    <= saved_fwd;
            wait_ticks      <= '0;
            step_high       <= 1'b0;
            driver_on       <= 1'b1;
            done_flag       <= 1'b0;
            out_valid       <= 1'b1;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> !busy_res)
    else $error("done beat while a move still runs");

  a_hp_done_in_calc: assert property (@(posedge clk) disable iff (rst)
    hp_done |-> state == S_CALC)
    else $error("half-period result outside a start");

  a_wait_below_period: assert property (@(posedge clk) disable iff (rst)
    running |-> wait_ticks < half_period)
    else $error("tick countdown beyond half-period");

  a_calc_no_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_CALC) |-> !out_valid)
    else $error("result beat shown while a start is computed");
`endif

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the constant-speed step generator against its own step/direction
// predictor: a short directed table, then random move sequences under four
// microstep and hold settings, with idling and back-pressure on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import cssg_pkg::*;

  localparam int RX_HOLD_CYCLES = 300;
  localparam int PHASE_BEATS    = 360;
  localparam int MAX_REPORTS    = 50;

  typedef struct packed {
    logic               step;
    logic               dir;
    logic               en_n;
    logic               busy;
    logic               done;
    logic signed [31:0] pos;
  } pins_t;

  typedef struct {
    op_t         op;
    logic [23:0] steps;
    logic        fwd;
    logic [15:0] rpm;
    bit          fixed;
    pins_t       want;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  op = 2'd0;
  logic [23:0] step_count = '0;
  logic        forward = 1'b0;
  logic [15:0] speed_rpm = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        step_level, dir_level, enable_n, busy_res, done_res;
  logic signed [31:0] position;

  // step generator mirror
  logic        sixteenth_cfg = 1'b1;
  logic        hold_cfg = 1'b1;
  logic [31:0] pos_cnt = '0;
  logic [31:0] target_pos = '0;
  logic        moving = 1'b0;
  logic        step_hi = 1'b0;
  logic        going_fwd = 1'b0;
  logic [15:0] half_ticks = 16'd1;
  logic [15:0] wait_cnt = '0;
  logic        drv_on = 1'b0;

  pins_t       pending_pins[$];
  script_row_t script[$];

  int  errors = 0;
  int  beats_in = 0;
  int  results_seen = 0;
  int  done_seen = 0;
  int  starts_sent = 0;
  bit  idle_on = 1'b1;
  bit  rx_hold_req = 1'b0;

  constant_speed_step_generator_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .step_count (step_count),
    .forward    (forward),
    .speed_rpm  (speed_rpm),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .step_level (step_level),
    .dir_level  (dir_level),
    .enable_n   (enable_n),
    .busy_res   (busy_res),
    .done_res   (done_res),
    .position   (position)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", pending_pins.size());
    $display("testbench: errors");
    $finish;
  end

  function automatic pins_t mk_pins(input logic s, input logic d, input logic e,
                                    input logic b, input logic dn,
                                    input logic signed [31:0] p);
    pins_t r;
    r.step = s;
    r.dir  = d;
    r.en_n = e;
    r.busy = b;
    r.done = dn;
    r.pos  = p;
    return r;
  endfunction

  // ticks per half step period for a given rpm under the current ratio
  function automatic logic [15:0] half_period_for(input logic [15:0] rpm);
    int unsigned rpm_c;
    int unsigned spr;
    int unsigned hp;
    rpm_c = (rpm > DEF_MAX_RPM) ? DEF_MAX_RPM : rpm;
    spr   = DEF_FULL_STEPS_PER_REV * (sixteenth_cfg ? MICRO_RATIO : 1);
    if (rpm_c == 0) return 16'd1;
    hp = TICKS_PER_MIN / (rpm_c * spr);
    if (hp == 0) hp = 1;
    return hp[15:0];
  endfunction

  function automatic logic [31:0] f_step(input logic [31:0] p);
    return going_fwd ? p + 32'd1 : p - 32'd1;
  endfunction

  function automatic pins_t step_motion(input op_t o, input logic [23:0] s,
                                        input logic f, input logic [15:0] r);
    logic fin;
    fin = 1'b0;
    case (o)
      OP_TICK: begin
        if (moving) begin
          if (wait_cnt != 16'd0) begin
            wait_cnt = wait_cnt - 16'd1;
          end else if (pos_cnt == target_pos) begin
            step_hi = 1'b0;
            drv_on  = hold_cfg;
            moving  = 1'b0;
            fin     = 1'b1;
          end else begin
            wait_cnt = half_ticks - 16'd1;
            if (!step_hi) begin
              step_hi = 1'b1;
            end else begin
              step_hi = 1'b0;
              pos_cnt = f_step(pos_cnt);
            end
          end
        end
      end
      OP_START: begin
        if (s == 24'd0 || r == 16'd0) begin
          step_hi = 1'b0;
          drv_on  = hold_cfg;
          moving  = 1'b0;
        end else begin
          half_ticks = half_period_for(r);
          moving     = 1'b1;
          target_pos = f ? pos_cnt + {8'd0, s} : pos_cnt - {8'd0, s};
          going_fwd  = f;
          wait_cnt   = 16'd0;
          step_hi    = 1'b0;
          drv_on     = 1'b1;
        end
      end
      OP_STOP: begin
        fin     = moving;
        moving  = 1'b0;
        step_hi = 1'b0;
        drv_on  = hold_cfg;
      end
      default: pos_cnt = '0;
    endcase
    return mk_pins(step_hi, ~going_fwd, ~drv_on, moving, fin, pos_cnt);
  endfunction

  task automatic report_mismatch(input string field, input longint want_v,
                                 input longint got_v);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("mismatch on result %0d: %s expected %0d got %0d",
               results_seen, field, want_v, got_v);
  endtask

  task automatic send_beat(input op_t o, input logic [23:0] s, input logic f,
                           input logic [15:0] r, input bit fixed, input pins_t want);
    pins_t p;
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   = 1'b1;
    op         = o;
    step_count = s;
    forward    = f;
    speed_rpm  = r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = step_motion(o, s, f, r);
    pending_pins.push_back(fixed ? want : p);
    beats_in++;
    if (o == OP_START) starts_sent++;
  endtask

  task automatic add_row(input op_t o, input logic [23:0] s, input logic f,
                         input logic [15:0] r, input bit fixed, input pins_t want);
    script_row_t row;
    row.op    = o;
    row.steps = s;
    row.fwd   = f;
    row.rpm   = r;
    row.fixed = fixed;
    row.want  = want;
    script.push_back(row);
  endtask

  task automatic wait_drained;
    int guard;
    guard = 0;
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_pins.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_addr = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_MICROSTEP) sixteenth_cfg = val;
    else hold_cfg = val;
  endtask

  // start/tick sequences with random content, plus some noise beats
  task automatic run_moves(input int quota);
    int stop_at;
    int n_ticks;
    logic [23:0] s;
    logic [15:0] r;
    logic f;
    stop_at = beats_in + quota;
    while (beats_in < stop_at) begin
      if ($urandom_range(0, 99) < 15) begin
        send_beat(op_t'($urandom_range(0, 3)), 24'($urandom), 1'($urandom),
                  16'($urandom), 1'b0, '0);
      end else begin
        s = ($urandom_range(0, 9) == 0) ? 24'($urandom_range(5, 40))
                                        : 24'($urandom_range(1, 4));
        case ($urandom_range(0, 9))
          0:       r = 16'($urandom);
          1, 2, 3: r = 16'($urandom_range(1, 40));
          4, 5:    r = 16'($urandom_range(200, 700));
          default: r = 16'($urandom_range(19, 65535));
        endcase
        f = 1'($urandom);
        send_beat(OP_START, s, f, r, 1'b0, '0);
        n_ticks = 2 * int'(s) * int'(half_period_for(r)) + 1 + $urandom_range(0, 2);
        if (r == 16'd0 || n_ticks > 200 || $urandom_range(0, 9) == 0)
          n_ticks = $urandom_range(1, 40);
        for (int i = 0; i < n_ticks; i++) begin
          if ($urandom_range(0, 59) == 0)
            send_beat($urandom_range(0, 1) ? OP_STOP : OP_ZERO, 24'($urandom),
                      1'($urandom), 16'($urandom), 1'b0, '0);
          else
            send_beat(OP_TICK, 24'($urandom), 1'($urandom), 16'($urandom), 1'b0, '0);
        end
      end
    end
  endtask

  // result side: random stalls, and one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        out_ready = 1'b0;
        repeat (RX_HOLD_CYCLES - 1) @(negedge clk);
        rx_hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 8) - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    pins_t want;
    pins_t got;
    if (!rst && out_valid && out_ready) begin
      got = mk_pins(step_level, dir_level, enable_n, busy_res, done_res, position);
      if (got.done === 1'b1) done_seen++;
      if (pending_pins.size() == 0) begin
        report_mismatch("unexpected result beat", 0, 1);
      end else begin
        want = pending_pins.pop_front();
        if (got.step !== want.step) report_mismatch("step_level", want.step, got.step);
        if (got.dir !== want.dir) report_mismatch("dir_level", want.dir, got.dir);
        if (got.en_n !== want.en_n) report_mismatch("enable_n", want.en_n, got.en_n);
        if (got.busy !== want.busy) report_mismatch("busy_res", want.busy, got.busy);
        if (got.done !== want.done) report_mismatch("done_res", want.done, got.done);
        if (got.pos !== want.pos) report_mismatch("position", want.pos, got.pos);
      end
      results_seen++;
    end
  end

  initial begin
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // directed part, reset register values
    add_row(OP_TICK, 24'd0, 1'b0, 16'd0, 1'b1, mk_pins(0, 1, 1, 0, 0, 0));
    add_row(OP_STOP, 24'd0, 1'b0, 16'd0, 1'b1, mk_pins(0, 1, 0, 0, 0, 0));
    add_row(OP_ZERO, 24'hFFFFFF, 1'b1, 16'hFFFF, 1'b1, mk_pins(0, 1, 0, 0, 0, 0));
    add_row(OP_START, 24'd0, 1'b1, 16'd100, 1'b1, mk_pins(0, 1, 0, 0, 0, 0));
    add_row(OP_START, 24'd5, 1'b1, 16'd0, 1'b1, mk_pins(0, 1, 0, 0, 0, 0));
    // clamped rpm, two steps forward
    add_row(OP_START, 24'd2, 1'b1, 16'hFFFF, 1'b1, mk_pins(0, 0, 0, 1, 0, 0));
    for (int i = 0; i < 6; i++) add_row(OP_TICK, 24'd0, 1'b0, 16'd0, 1'b0, '0);
    add_row(OP_START, 24'hFFFFFF, 1'b0, 16'd1, 1'b1, mk_pins(0, 1, 0, 1, 0, 2));
    add_row(OP_TICK, 24'd0, 1'b0, 16'd0, 1'b0, '0);
    add_row(OP_TICK, 24'd0, 1'b0, 16'd0, 1'b0, '0);
    add_row(OP_ZERO, 24'd0, 1'b0, 16'd0, 1'b0, '0);
    // replaces the running move
    add_row(OP_START, 24'd3, 1'b1, 16'd600, 1'b0, '0);
    add_row(OP_TICK, 24'd0, 1'b0, 16'd0, 1'b0, '0);
    add_row(OP_TICK, 24'd0, 1'b0, 16'd0, 1'b0, '0);
    add_row(OP_STOP, 24'd0, 1'b0, 16'd0, 1'b1, mk_pins(0, 0, 0, 0, 1, 1));
    add_row(OP_STOP, 24'd0, 1'b0, 16'd0, 1'b0, '0);
    add_row(OP_START, 24'd1, 1'b1, 16'd0, 1'b0, '0);
    foreach (script[i])
      send_beat(script[i].op, script[i].steps, script[i].fwd, script[i].rpm,
                script[i].fixed, script[i].want);

    // four register settings; a move is left running across each write
    for (int ph = 0; ph < 4; ph++) begin
      send_beat(OP_START, 24'd6, 1'b1, 16'd5, 1'b0, '0);
      wait_drained();
      write_reg(CFG_MICROSTEP, ph[0]);
      write_reg(CFG_HOLD, ph[1]);
      if (ph == 1) rx_hold_req = 1'b1;
      if (ph == 3) idle_on = 1'b0;
      repeat (4) send_beat(OP_TICK, 24'd0, 1'b0, 16'd0, 1'b0, '0);
      run_moves(PHASE_BEATS);
      // sender waits for every result before moving on
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (pending_pins.size() != 0)
      report_mismatch("results never delivered", 0, pending_pins.size());
    $display("covered %0d beats (%0d starts) under 4 microstep/hold settings",
             beats_in, starts_sent);
    $display("checked %0d results, %0d with a done pulse, %0d mismatches",
             results_seen, done_seen, errors);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
